@@ rtl/core/byte_pattern_find_replace_assert.svh @@
// Assertion macros shared by the find-and-replace RTL
`ifndef BYTE_PATTERN_FIND_REPLACE_ASSERT_SVH
`define BYTE_PATTERN_FIND_REPLACE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define BPFR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication
`define BPFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define BPFR_ASSERT_IMP(label, clk, rst, ante, cons)
`define BPFR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/core/bpfr_pkg.sv @@
// Types and constants for the byte pattern find-and-replace block
`timescale 1ns / 1ps

package bpfr_pkg;

  // Needle and replacement store depth, fixed by the 5-bit index field
  localparam int STORE_DEPTH = 32;
  localparam logic [5:0] NEEDLE_MIN = 6'd5;
  localparam logic [5:0] SINCE_MAX = 6'd63;
  localparam logic [28:0] COUNT_MAX = 29'h1FFF_FFFF;

  // Configuration register indexes
  localparam logic [1:0] REG_NEEDLE_LENGTH = 2'd0;
  localparam logic [1:0] REG_REPLACE_LENGTH = 2'd1;
  localparam logic [1:0] REG_DRY_RUN = 2'd2;

  typedef enum logic [1:0] {
    ACT_LOAD_NEEDLE = 2'd0,
    ACT_LOAD_REPLACE = 2'd1,
    ACT_DATA = 2'd2,
    ACT_FLUSH = 2'd3
  } action_t;

  typedef struct packed {
    action_t action;
    logic [4:0] index;
    logic [7:0] value;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [28:0] out_offset;
    logic match_start;
    logic [28:0] match_count;
    logic last;
  } result_t;

  typedef struct packed {
    logic [5:0] needle_length;
    logic [5:0] replace_length;
    logic dry_run;
  } cfg_t;

endpackage

@@ rtl/core/bpfr_match_core.sv @@
// Window shift, parallel needle compare and span replacement
`timescale 1ns / 1ps
`include "byte_pattern_find_replace_assert.svh"

module bpfr_match_core #(
  parameter int WIN = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic pend_valid,
  input  bpfr_pkg::item_t pend,
  input  bpfr_pkg::cfg_t cfg,
  input  logic space,
  output logic done,
  output logic push,
  output bpfr_pkg::result_t push_data
);

  localparam int FW = $clog2(WIN + 1);
  localparam int PW = $clog2(WIN);

  // Stores, written by load beats, read lane by lane
  logic [7:0] needle_mem [bpfr_pkg::STORE_DEPTH];
  logic [7:0] subst_mem [bpfr_pkg::STORE_DEPTH];

  // Window state
  logic [7:0] win [WIN];
  logic [WIN-1:0] flags;
  logic [FW-1:0] fill;
  logic [5:0] since_match;
  logic [28:0] emit_position;
  logic [28:0] matches_seen;

  logic [5:0] len;
  logic [5:0] rep;
  logic [5:0] fill6;
  logic emit;
  logic ins;
  logic last_beat;
  logic hit;
  logic [7:0] w_sh [WIN];
  logic [7:0] w_ins [WIN];
  logic [7:0] win_next [WIN];
  logic [WIN-1:0] f_sh;
  logic [WIN-1:0] f_ins;
  logic [WIN-1:0] flags_next;
  logic [FW-1:0] fill_sh;
  logic [FW-1:0] fill_next;
  logic [5:0] since_next;
  logic [WIN-1:0] lane_ok;

  // Effective needle and replacement lengths
  always_comb begin
    if (cfg.needle_length < bpfr_pkg::NEEDLE_MIN) begin
      len = bpfr_pkg::NEEDLE_MIN;
    end else if (cfg.needle_length > 6'(WIN)) begin
      len = 6'(WIN);
    end else begin
      len = cfg.needle_length;
    end
    rep = (cfg.replace_length > len) ? len : cfg.replace_length;
  end

  assign fill6 = 6'(fill);

  // Step control: what this beat does in this cycle
  always_comb begin
    done = 1'b0;
    emit = 1'b0;
    ins = 1'b0;
    last_beat = 1'b0;
    case (pend.action)
      bpfr_pkg::ACT_LOAD_NEEDLE, bpfr_pkg::ACT_LOAD_REPLACE: begin
        done = 1'b1;
      end
      bpfr_pkg::ACT_FLUSH: begin
        if (fill6 == 6'd0) begin
          done = 1'b1;
        end else begin
          emit = space;
          last_beat = (fill6 == 6'd1);
          done = space && last_beat;
        end
      end
      bpfr_pkg::ACT_DATA: begin
        if (fill6 > len) begin
          // needle shrank: drain the excess first
          emit = space;
        end else if (fill6 == len) begin
          emit = space;
          ins = space;
          done = space;
        end else begin
          ins = 1'b1;
          done = 1'b1;
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase
    done = done && pend_valid;
    emit = emit && pend_valid;
    ins = ins && pend_valid;
  end

  // Shift out the oldest byte, then insert the new one
  always_comb begin
    w_sh = win;
    f_sh = flags;
    fill_sh = fill;
    if (emit) begin
      for (int i = 0; i < WIN - 1; i++) begin
        w_sh[i] = win[i+1];
      end
      w_sh[WIN-1] = 8'd0;
      f_sh = flags >> 1;
      fill_sh = fill - FW'(1);
    end
    w_ins = w_sh;
    f_ins = f_sh;
    fill_next = fill_sh;
    since_next = since_match;
    if (ins) begin
      w_ins[fill_sh[PW-1:0]] = pend.value;
      f_ins[fill_sh[PW-1:0]] = 1'b0;
      fill_next = fill_sh + FW'(1);
      if (since_match < bpfr_pkg::SINCE_MAX) begin
        since_next = since_match + 6'd1;
      end
    end
  end

  // Parallel compare of the window against the needle
  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      lane_ok[i] = (6'(i) >= len) || (w_ins[i] == needle_mem[i]);
    end
    hit = ins && (6'(fill_next) == len) && (since_next >= len) && (&lane_ok);
  end

  // Overwrite the matched span unless dry run
  always_comb begin
    win_next = w_ins;
    flags_next = f_ins;
    if (hit) begin
      flags_next[0] = 1'b1;
      if (!cfg.dry_run) begin
        for (int i = 0; i < WIN; i++) begin
          if (6'(i) < len) begin
            win_next[i] = (6'(i) < rep) ? subst_mem[i] : 8'd0;
          end
        end
      end
    end
  end

  // Result for the byte leaving the window
  always_comb begin
    push = emit;
    push_data.out_byte = win[0];
    push_data.out_offset = emit_position;
    push_data.match_start = flags[0];
    push_data.match_count = matches_seen;
    push_data.last = last_beat;
  end

  // Store writes
  always_ff @(posedge clk) begin
    if (pend_valid && pend.action == bpfr_pkg::ACT_LOAD_NEEDLE) begin
      needle_mem[pend.index] <= pend.value;
    end
    if (pend_valid && pend.action == bpfr_pkg::ACT_LOAD_REPLACE) begin
      subst_mem[pend.index] <= pend.value;
    end
  end

  // Window bytes (payload, no reset)
  always_ff @(posedge clk) begin
    if (emit || ins) begin
      win <= win_next;
    end
  end

  // Window control state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
      fill <= '0;
      since_match <= bpfr_pkg::SINCE_MAX;
      emit_position <= '0;
      matches_seen <= '0;
    end else begin
      if (emit || ins) begin
        flags <= flags_next;
        fill <= fill_next;
      end
      if (hit) begin
        since_match <= 6'd0;
      end else begin
        since_match <= since_next;
      end
      if (emit && emit_position != bpfr_pkg::COUNT_MAX) begin
        emit_position <= emit_position + 29'd1;
      end
      if (hit && matches_seen != bpfr_pkg::COUNT_MAX) begin
        matches_seen <= matches_seen + 29'd1;
      end
    end
  end

  `BPFR_ASSERT_IMP(a_emit_room, clk, rst, emit, space)
  `BPFR_ASSERT_NEXT(a_flush_drains, clk, rst, done && pend.action == bpfr_pkg::ACT_FLUSH, fill == '0)
  `BPFR_ASSERT_NEXT(a_count_mono, clk, rst, 1'b1, matches_seen >= $past(matches_seen))

endmodule

@@ rtl/core/bpfr_out_queue.sv @@
// Two-entry result queue between the window and the result channel
`timescale 1ns / 1ps
`include "byte_pattern_find_replace_assert.svh"

module bpfr_out_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  bpfr_pkg::result_t push_data,
  output logic space,
  output logic result_valid,
  input  logic result_stall,
  output bpfr_pkg::result_t result
);

  bpfr_pkg::result_t slots [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;
  logic pop;

  assign space = (count != 2'd2);
  assign result_valid = (count != 2'd0);
  assign result = slots[rd_ptr];
  assign pop = result_valid && !result_stall;

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  `BPFR_ASSERT_IMP(a_no_overflow, clk, rst, push, count != 2'd2)
  `BPFR_ASSERT_NEXT(a_full_drains, clk, rst, count == 2'd2 && !result_stall, count == 2'd1)

endmodule

@@ rtl/core/byte_pattern_find_replace.sv @@
// Streaming fixed-pattern find and replace: one data byte per cycle in steady state while
// the result channel does not stall. Load beats fill the needle and replacement stores, data
// beats stream bytes through a window of needle_length bytes that is compared against the
// needle in parallel, and a flush beat drains the window. A flush empties the window one
// byte at a time, and a data beat after needle_length was lowered first drains each byte by
// which the window exceeds the new length. The single result port of the window (one byte
// leaves per cycle while the result queue has space) sets this pace. Bytes leave delayed by
// the window depth: result beats for a match appear as the matched bytes are pushed out.
// Configuration must be written only while the block is idle; the block itself does not
// enforce this.
`timescale 1ns / 1ps

module byte_pattern_find_replace #(
  parameter int MAX_PATTERN = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_stall,
  input  bpfr_pkg::item_t item,
  output logic result_valid,
  input  logic result_stall,
  output bpfr_pkg::result_t result,
  input  logic cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_data
);

  localparam int WIN = (MAX_PATTERN < bpfr_pkg::STORE_DEPTH) ? MAX_PATTERN
                                                             : bpfr_pkg::STORE_DEPTH;

  bpfr_pkg::cfg_t cfg;
  bpfr_pkg::item_t pend;
  logic pend_valid;
  logic done;
  logic space;
  logic push;
  bpfr_pkg::result_t push_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.needle_length <= bpfr_pkg::NEEDLE_MIN;
      cfg.replace_length <= 6'd0;
      cfg.dry_run <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        bpfr_pkg::REG_NEEDLE_LENGTH: cfg.needle_length <= cfg_data;
        bpfr_pkg::REG_REPLACE_LENGTH: cfg.replace_length <= cfg_data;
        bpfr_pkg::REG_DRY_RUN: cfg.dry_run <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register: holds the beat until the window has finished with it
  assign item_stall = pend_valid && !done;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      pend_valid <= 1'b1;
    end else if (done) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      pend <= item;
    end
  end

  bpfr_match_core #(
    .WIN(WIN)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .pend_valid(pend_valid),
    .pend(pend),
    .cfg(cfg),
    .space(space),
    .done(done),
    .push(push),
    .push_data(push_data)
  );

  bpfr_out_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data(push_data),
    .space(space),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

endmodule

@@ tb/find_replace_checker.sv @@
// Checker for the find-and-replace block: predicts every output beat and compares it
`timescale 1ns / 1ps

module find_replace_checker
  import bpfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  logic       item_stall,
  input  item_t      item,
  input  logic       result_valid,
  input  logic       result_stall,
  input  result_t    result,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_data,
  output int         fail_count,
  output int         pending
);

  localparam int REPORT_LIMIT = 10;

  // Predicted block state
  logic [7:0]  needle_mem [STORE_DEPTH];
  logic [7:0]  subst_mem [STORE_DEPTH];
  logic [7:0]  win_byte [STORE_DEPTH];
  logic        win_flag [STORE_DEPTH];
  int          win_fill;
  logic [5:0]  since_hit;
  logic [28:0] next_offset;
  logic [28:0] hit_total;
  cfg_t        cfg;

  // Output beats predicted but not yet seen, oldest first
  result_t out_due [$];

  // Oldest window byte leaves as an output beat
  task automatic shift_oldest(input logic is_last);
    result_t beat;
    beat.out_byte = win_byte[0];
    beat.out_offset = next_offset;
    beat.match_start = win_flag[0];
    beat.match_count = hit_total;
    beat.last = is_last;
    out_due.push_back(beat);
    if (next_offset != COUNT_MAX) next_offset++;
    for (int k = 0; k < STORE_DEPTH - 1; k++) begin
      win_byte[k] = win_byte[k + 1];
      win_flag[k] = win_flag[k + 1];
    end
    win_byte[STORE_DEPTH - 1] = 8'h00;
    win_flag[STORE_DEPTH - 1] = 1'b0;
    if (win_fill > 0) win_fill--;
  endtask

  // Advance the window model by one accepted input beat
  task automatic step_window(input item_t beat);
    int len;
    int rep;
    bit hit;
    len = int'(cfg.needle_length);
    if (len < int'(NEEDLE_MIN)) len = int'(NEEDLE_MIN);
    if (len > STORE_DEPTH) len = STORE_DEPTH;
    rep = (int'(cfg.replace_length) > len) ? len : int'(cfg.replace_length);
    case (beat.action)
      ACT_LOAD_NEEDLE: needle_mem[beat.index] = beat.value;
      ACT_LOAD_REPLACE: subst_mem[beat.index] = beat.value;
      ACT_FLUSH: begin
        while (win_fill > 0) shift_oldest(win_fill == 1);
      end
      ACT_DATA: begin
        // shed old bytes until the window fits the current needle
        while (win_fill >= len) shift_oldest(1'b0);
        win_byte[win_fill] = beat.value;
        win_flag[win_fill] = 1'b0;
        win_fill++;
        if (since_hit != SINCE_MAX) since_hit++;
        // compare only on a full window clear of the last hit
        if (win_fill == len && int'(since_hit) >= len) begin
          hit = 1'b1;
          for (int k = 0; k < len; k++) begin
            if (win_byte[k] !== needle_mem[k]) hit = 1'b0;
          end
          if (hit) begin
            win_flag[0] = 1'b1;
            since_hit = '0;
            if (hit_total != COUNT_MAX) hit_total++;
            if (!cfg.dry_run) begin
              for (int k = 0; k < len; k++) begin
                win_byte[k] = (k < rep) ? subst_mem[k] : 8'h00;
              end
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // Watch config writes and both channels on every rising edge
  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      for (int k = 0; k < STORE_DEPTH; k++) begin
        win_byte[k] = 8'h00;
        win_flag[k] = 1'b0;
      end
      win_fill = 0;
      since_hit = SINCE_MAX;
      next_offset = '0;
      hit_total = '0;
      cfg.needle_length = NEEDLE_MIN;
      cfg.replace_length = '0;
      cfg.dry_run = 1'b0;
      out_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_NEEDLE_LENGTH: cfg.needle_length = cfg_data;
          REG_REPLACE_LENGTH: cfg.replace_length = cfg_data;
          REG_DRY_RUN: cfg.dry_run = cfg_data[0];
          default: ;
        endcase
      end
      if (item_valid && !item_stall) step_window(item);
      if (result_valid && !result_stall) begin
        if (out_due.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("unexpected output beat: byte %02h off %0d start %0b count %0d last %0b",
                     result.out_byte, result.out_offset, result.match_start,
                     result.match_count, result.last);
        end else begin
          want = out_due.pop_front();
          if (result.out_byte !== want.out_byte || result.out_offset !== want.out_offset ||
              result.match_start !== want.match_start ||
              result.match_count !== want.match_count || result.last !== want.last) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("out beat mismatch: want byte %02h off %0d start %0b count %0d last %0b",
                       want.out_byte, want.out_offset, want.match_start,
                       want.match_count, want.last);
              $display("                   got  byte %02h off %0d start %0b count %0d last %0b",
                       result.out_byte, result.out_offset, result.match_start,
                       result.match_count, result.last);
            end
          end
        end
      end
    end
    pending = out_due.size();
  end

endmodule

@@ tb/testbench.sv @@
// Testbench top for the find-and-replace block: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;
  import bpfr_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;

  // Idle modes for the two channels
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  logic       clk;
  logic       rst;
  logic       item_valid;
  logic       item_stall;
  item_t      item;
  logic       result_valid;
  logic       result_stall;
  result_t    result;
  logic       cfg_write;
  logic [1:0] cfg_index;
  logic [5:0] cfg_data;

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_request = 1'b0;
  bit hold_served = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  // Current needle contents, used to build matching streams
  logic [7:0] needle_img [STORE_DEPTH];

  byte_pattern_find_replace u_top (
    .clk,
    .rst,
    .item_valid,
    .item_stall,
    .item,
    .result_valid,
    .result_stall,
    .result,
    .cfg_write,
    .cfg_index,
    .cfg_data
  );

  find_replace_checker u_checker (
    .clk,
    .rst,
    .item_valid,
    .item_stall,
    .item,
    .result_valid,
    .result_stall,
    .result,
    .cfg_write,
    .cfg_index,
    .cfg_data,
    .fail_count,
    .pending
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (hold_request != hold_served) begin
      hold_served = hold_request;
      hold_left = HOLD_CYCLES - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Watchdog: too long without any beat or register write
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one input beat and hold it until accepted
  task automatic send_beat(input action_t act, input logic [4:0] idx, input logic [7:0] val);
    item_t beat;
    beat.action = act;
    beat.index = idx;
    beat.value = val;
    if (act == ACT_LOAD_NEEDLE) needle_img[idx] = val;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= beat;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  // Wait until every predicted beat is out and the block has gone quiet
  task automatic settle();
    item_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write all three registers while idle
  task automatic program_regs(input logic [5:0] nlen, input logic [5:0] rlen, input logic dry);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= REG_NEEDLE_LENGTH;
    cfg_data <= nlen;
    @(negedge clk);
    cfg_index <= REG_REPLACE_LENGTH;
    cfg_data <= rlen;
    @(negedge clk);
    cfg_index <= REG_DRY_RUN;
    cfg_data <= {5'($urandom), dry};
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // One random phase under a given setting and idle mode
  task automatic run_phase(input logic [5:0] nlen, input logic [5:0] rlen, input logic dry,
                           input int idle_mode, input bit squeeze);
    int len;
    int budget;
    int sent;
    int pick;
    int n;
    program_regs(nlen, rlen, dry);
    len = (nlen < NEEDLE_MIN) ? int'(NEEDLE_MIN) : (nlen > STORE_DEPTH) ? STORE_DEPTH : int'(nlen);
    case (idle_mode)
      IDLE_NONE: begin send_idle_pct = 0; recv_stall_pct = 0; end
      IDLE_SEND: begin send_idle_pct = 70; recv_stall_pct = 0; end
      IDLE_RECV: begin send_idle_pct = 0; recv_stall_pct = 70; end
      default: begin send_idle_pct = 14; recv_stall_pct = 14; end
    endcase
    // receiver holds off while the sender keeps offering, so the block backs up
    if (squeeze) hold_request = ~hold_request;
    budget = 4 + len + (squeeze ? 40 : 0);
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        // copy of the needle, one byte spoiled now and then
        n = ($urandom_range(0, 99) < 20) ? $urandom_range(0, len - 1) : -1;
        for (int k = 0; k < len; k++)
          send_beat(ACT_DATA, 5'($urandom), (k == n) ? ~needle_img[k] : needle_img[k]);
        sent += len;
      end else if (pick < 80) begin
        // short noise run, each byte drawn from the needle alphabet or at random
        n = $urandom_range(1, 4);
        repeat (n)
          send_beat(ACT_DATA, 5'($urandom), $urandom_range(0, 1) ?
                    needle_img[$urandom_range(0, len - 1)] : 8'($urandom));
        sent += n;
      end else if (pick < 88) begin
        send_beat(ACT_FLUSH, 5'($urandom), 8'($urandom));
        sent++;
      end else begin
        send_beat($urandom_range(0, 1) ? ACT_LOAD_REPLACE : ACT_LOAD_NEEDLE,
                  5'($urandom), 8'($urandom));
        sent++;
      end
    end
  endtask

  // Stimulus and verdict
  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_stall = 1'b0;
    cfg_write = 1'b0;
    cfg_index = REG_NEEDLE_LENGTH;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // needle of five equal bytes: only one hit in a run of seven, then flushes
    for (int k = 0; k < 5; k++) send_beat(ACT_LOAD_NEEDLE, 5'(k), 8'hAA);
    send_beat(ACT_LOAD_NEEDLE, 5'd31, 8'hFF);
    send_beat(ACT_LOAD_REPLACE, 5'd31, 8'h00);
    repeat (7) send_beat(ACT_DATA, 5'd0, 8'hAA);
    send_beat(ACT_FLUSH, 5'd31, 8'hFF);
    // flush of an empty window
    send_beat(ACT_FLUSH, 5'd0, 8'h00);

    // window holding seven bytes while the needle shrinks from eight to five
    program_regs(6'd8, 6'd0, 1'b0);
    send_beat(ACT_DATA, 5'd31, 8'h00);
    send_beat(ACT_DATA, 5'd0, 8'hFF);
    repeat (5) send_beat(ACT_DATA, 5'd0, 8'hAA);
    program_regs(6'd5, 6'd0, 1'b0);
    send_beat(ACT_DATA, 5'd0, 8'hAA);
    send_beat(ACT_FLUSH, 5'd0, 8'h00);

    // fill both stores so every later read hits a written entry
    for (int k = 0; k < STORE_DEPTH; k++) begin
      send_beat(ACT_LOAD_NEEDLE, 5'(k), 8'($urandom));
      send_beat(ACT_LOAD_REPLACE, 5'(k), 8'($urandom));
    end

    // random phases across settings, out-of-range lengths among them
    run_phase(6'd5, 6'd0, 1'b0, IDLE_NONE, 1'b0);
    run_phase(6'd32, 6'd32, 1'b0, IDLE_SEND, 1'b0);
    run_phase(6'd0, 6'd63, 1'b0, IDLE_RECV, 1'b0);
    run_phase(6'd63, 6'd7, 1'b1, IDLE_BOTH, 1'b0);
    run_phase(6'd12, 6'd5, 1'b0, IDLE_NONE, 1'b1);
    run_phase(6'd7, 6'd63, 1'b1, IDLE_SEND, 1'b0);
    run_phase(6'd20, 6'd20, 1'b0, IDLE_RECV, 1'b0);
    run_phase(6'd6, 6'd2, 1'b0, IDLE_BOTH, 1'b0);

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
